>>> sv/tcw_pkg.sv
package tcw_pkg;

  localparam int SCREEN_WIDTH_DEF  = 80;
  localparam int SCREEN_HEIGHT_DEF = 25;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int CELL_W   = 16;
  localparam int COLOR_W  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int TAB_STEP = 5;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

  localparam logic [CELL_W-1:0]  BLANK_RESET = 16'h0720;
  localparam logic [COLOR_W-1:0] FG_RESET    = 4'd7;
  localparam logic [COLOR_W-1:0] BG_RESET    = 4'd0;

  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'b1;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    OP_READ,
    OP_PUT,
    OP_NEWLINE,
    OP_RETURN,
    OP_TAB,
    OP_BACKSPACE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
  } item_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL
  } back_state_t;

endpackage

>>> sv/tcw_front.sv
module tcw_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcw_pkg::INDEX_W-1:0]   in_cell_index,
  input  logic                          q_full,
  input  tcw_pkg::back_status_t         status,
  output logic                          push,
  output tcw_pkg::item_t                push_item
);
  import tcw_pkg::*;

  function automatic op_t classify(input logic cmd, input logic [CHAR_W-1:0] ch);
    op_t op;
    if (cmd == CMD_READ) begin
      op = OP_READ;
    end else begin
      case (ch)
        CHAR_NEWLINE:   op = OP_NEWLINE;
        CHAR_RETURN:    op = OP_RETURN;
        CHAR_TAB:       op = OP_TAB;
        CHAR_BACKSPACE: op = OP_BACKSPACE;
        default:        op = OP_PUT;
      endcase
    end
    return op;
  endfunction

  assign in_stall = q_full || status.clearing;
  assign push     = in_valid && !in_stall;

  always_comb begin
    push_item.op         = classify(in_command, in_char_code);
    push_item.char_code  = in_char_code;
    push_item.cell_index = in_cell_index;
  end

endmodule

>>> sv/tcw_queue.sv
module tcw_queue #(
  parameter int DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tcw_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tcw_pkg::item_t head_item
);
  import tcw_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  item_t         slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;

  assign full      = count_r == NW'(DEPTH);
  assign empty     = count_r == '0;
  assign head_item = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> sv/tcw_back.sv
module tcw_back #(
  parameter int SCREEN_WIDTH  = tcw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tcw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  tcw_pkg::item_t                q_item,
  output logic                          q_pop,
  input  logic [tcw_pkg::COLOR_W-1:0]   fg_color,
  input  logic [tcw_pkg::COLOR_W-1:0]   bg_color,
  output tcw_pkg::back_status_t         status,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcw_pkg::CELL_W-1:0]    out_read_data,
  output logic [tcw_pkg::INDEX_W-1:0]   out_cursor_index,
  output logic                          out_scrolled
);
  import tcw_pkg::*;

  localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(SCREEN_WIDTH);
  localparam int RW    = $clog2(SCREEN_HEIGHT);

  back_state_t     state_r, state_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [AW-1:0]   base_r, base_nxt;
  logic            wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]   wr_addr_r, wr_addr_nxt;
  logic            rd_ok_r, rd_ok_nxt;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;

  logic                out_valid_r;
  logic [CELL_W-1:0]   out_data_r;
  logic [INDEX_W-1:0]  out_cursor_r;
  logic                out_scrolled_r;
  logic                load;
  logic [CELL_W-1:0]   load_data;
  logic                load_scrolled;
  logic [AW-1:0]       cursor_sum;

  logic [2*COLOR_W-1:0] color;
  logic [CELL_W-1:0]    blank;
  logic [AW-1:0]        cur_addr;
  logic                 last_row;
  logic [CW:0]          tab_sum;
  logic [CW:0]          put_sum;
  logic                 tab_wrap;
  logic                 put_wrap;
  logic                 wrap_row;
  logic                 scroll_hit;
  logic                 pop;
  logic                 rd_in_range;

  assign color       = {bg_color, fg_color};
  assign blank       = {color, CHAR_SPACE};
  assign cur_addr    = base_r + AW'(col_r);
  assign last_row    = row_r == RW'(SCREEN_HEIGHT - 1);
  assign tab_sum     = {1'b0, col_r} + (CW+1)'(TAB_STEP);
  assign put_sum     = {1'b0, col_r} + 1'b1;
  assign tab_wrap    = tab_sum >= (CW+1)'(SCREEN_WIDTH);
  assign put_wrap    = put_sum >= (CW+1)'(SCREEN_WIDTH);
  assign rd_in_range = 32'(q_item.cell_index) < CELLS;
  assign pop         = !q_empty && (state_r == ST_IDLE) && (!out_valid_r || !out_stall);
  assign q_pop       = pop;
  assign status.clearing = state_r == ST_CLEAR;

  always_comb begin
    case (q_item.op)
      OP_NEWLINE: wrap_row = 1'b1;
      OP_TAB:     wrap_row = tab_wrap;
      OP_PUT:     wrap_row = put_wrap;
      default:    wrap_row = 1'b0;
    endcase
  end
  assign scroll_hit = wrap_row && last_row;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (idx_r == AW'(CELLS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (pop) begin
          if (q_item.op == OP_READ) begin
            state_nxt = ST_READ;
          end else if (scroll_hit) begin
            state_nxt = ST_COPY;
          end
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      ST_COPY: begin
        if (idx_r == AW'(CELLS - 1)) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (!wr_pend_r && idx_r == AW'(CELLS - 1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_nxt       = idx_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    rd_ok_nxt     = rd_ok_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = blank;
    mem_raddr     = idx_r;
    load          = 1'b0;
    load_data     = '0;
    load_scrolled = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = BLANK_RESET;
        idx_nxt   = (idx_r == AW'(CELLS - 1)) ? '0 : idx_r + 1'b1;
      end
      ST_IDLE: begin
        if (pop) begin
          case (q_item.op)
            OP_READ: begin
              mem_raddr = rd_in_range ? AW'(q_item.cell_index) : '0;
              rd_ok_nxt = rd_in_range;
            end
            OP_RETURN: col_nxt = '0;
            OP_TAB: col_nxt = CW'(tab_sum);
            OP_BACKSPACE: begin
              if (col_r != '0) begin
                col_nxt   = col_r - 1'b1;
                mem_we    = 1'b1;
                mem_waddr = cur_addr - 1'b1;
              end else if (row_r != '0) begin
                row_nxt   = row_r - 1'b1;
                base_nxt  = base_r - AW'(SCREEN_WIDTH);
                mem_we    = 1'b1;
                mem_waddr = base_r - AW'(SCREEN_WIDTH);
              end
            end
            OP_PUT: begin
              mem_we    = 1'b1;
              mem_waddr = cur_addr;
              mem_wdata = {color, q_item.char_code};
              col_nxt   = CW'(put_sum);
            end
            default: col_nxt = col_r;
          endcase
          // move to the start of the next row
          if (wrap_row) begin
            col_nxt = '0;
            if (!last_row) begin
              row_nxt  = row_r + 1'b1;
              base_nxt = base_r + AW'(SCREEN_WIDTH);
            end
          end
          if (scroll_hit) begin
            idx_nxt = AW'(SCREEN_WIDTH);
          end else if (q_item.op != OP_READ) begin
            load = 1'b1;
          end
        end
      end
      ST_READ: begin
        load      = 1'b1;
        load_data = rd_ok_r ? rdata_r : '0;
      end
      ST_COPY: begin
        if (wr_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_r;
          mem_wdata = rdata_r;
        end
        mem_raddr   = idx_r;
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = idx_r - AW'(SCREEN_WIDTH);
        idx_nxt     = (idx_r == AW'(CELLS - 1)) ?
                      AW'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH) : idx_r + 1'b1;
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (wr_pend_r) begin
          mem_waddr = wr_addr_r;
          mem_wdata = rdata_r;
        end else if (idx_r == AW'(CELLS - 1)) begin
          idx_nxt       = '0;
          load          = 1'b1;
          load_scrolled = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: idx_nxt = '0;
    endcase
    cursor_sum = base_nxt + AW'(col_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      base_r      <= '0;
      wr_pend_r   <= 1'b0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      base_r    <= base_nxt;
      wr_pend_r <= wr_pend_nxt;
      rd_ok_r   <= rd_ok_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= wr_addr_nxt;
    if (load) begin
      out_data_r     <= load_data;
      out_cursor_r   <= INDEX_W'(cursor_sum);
      out_scrolled_r <= load_scrolled;
    end
  end

  // screen store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_data_r;
  assign out_cursor_index = out_cursor_r;
  assign out_scrolled     = out_scrolled_r;

`ifndef ASSERT_OFF
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(col_r) < SCREEN_WIDTH) && (32'(row_r) < SCREEN_HEIGHT))
    else $error("cursor off screen");

  a_row_base_match: assert property (@(posedge clk) disable iff (!rst_n)
    32'(base_r) == 32'(row_r) * SCREEN_WIDTH)
    else $error("row base out of step with cursor row");

  a_pend_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> (state_r == ST_COPY || state_r == ST_FILL))
    else $error("copy write pending outside scroll");

  a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!out_valid_r && !q_pop))
    else $error("activity during clearing pass");
`endif

endmodule

>>> sv/text_console_character_writer.sv
// Text console character writer: a screen of 16-bit cells plus a cursor.
// Input channel (in_valid / in_stall): in_command 0 puts in_char_code at the
// cursor (newline, return, tab and backspace act on the cursor), 1 reads the
// cell at in_cell_index. Every beat yields one result beat on the output
// channel (out_valid / out_stall): read data, cursor index, scroll flag.
// Colors come from cfg_we / cfg_index / cfg_wdata; write them while idle.
// Accepted beats go through a short queue to the executing back end, which
// owns the cursor and a screen memory with one write and one registered read port.
// Path: a put passes the queue slot and the output register; a read also passes
// the registered memory read port in ST_READ. A put that scrolls copies every row
// up, one cell moved per cycle through the memory port, blanks the bottom row,
// and the queue then fills. Throughput: one put per cycle while out_stall is low;
// a read holds the back end in ST_READ before it takes the next beat.
// Reset: synchronous, rst_n low; then the memory is swept to blank, in_stall high.
// A stalled result beat holds its value; the back end stops and the queue
// fills, after which in_stall rises.
module text_console_character_writer #(
  parameter int SCREEN_WIDTH  = tcw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tcw_pkg::SCREEN_HEIGHT_DEF,
  parameter int QUEUE_DEPTH   = tcw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]      in_char_code,
  input  logic [tcw_pkg::INDEX_W-1:0]     in_cell_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tcw_pkg::CELL_W-1:0]      out_read_data,
  output logic [tcw_pkg::INDEX_W-1:0]     out_cursor_index,
  output logic                            out_scrolled
);
  import tcw_pkg::*;

  logic [COLOR_W-1:0] fg_r;
  logic [COLOR_W-1:0] bg_r;
  back_status_t       status;
  logic               push;
  item_t              push_item;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  item_t              q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOREGROUND: fg_r <= COLOR_W'(cfg_wdata);
        REG_BACKGROUND: bg_r <= COLOR_W'(cfg_wdata);
        default: fg_r <= fg_r;
      endcase
    end
  end

  tcw_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .q_full        (q_full),
    .status        (status),
    .push          (push),
    .push_item     (push_item)
  );

  tcw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_item (q_item)
  );

  tcw_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .fg_color         (fg_r),
    .bg_color         (bg_r),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_cursor_index (out_cursor_index),
    .out_scrolled     (out_scrolled)
  );

endmodule

>>> dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLS        = SCREEN_WIDTH_DEF;
  localparam int ROWS        = SCREEN_HEIGHT_DEF;
  localparam int CELL_COUNT  = COLS * ROWS;
  localparam int CYCLE_LIMIT = 12_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 8;

  typedef struct packed {
    logic [CELL_W-1:0]  read_data;
    logic [INDEX_W-1:0] cursor_index;
    logic               scrolled;
  } console_beat_t;

  class console_shadow;
    logic [CELL_W-1:0]  cells [CELL_COUNT];
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [6:0]         col;
    logic [4:0]         row;
    console_beat_t      awaited[$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        puts;
    int unsigned        reads;
    int unsigned        scrolls;

    function new();
      fg = FG_RESET;
      bg = BG_RESET;
      col = '0;
      row = '0;
      foreach (cells[i]) cells[i] = BLANK_RESET;
    endfunction

    function void set_color(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_FOREGROUND) fg = val[COLOR_W-1:0];
      else if (idx == REG_BACKGROUND) bg = val[COLOR_W-1:0];
    endfunction

    function logic [CELL_W-1:0] colored(logic [CHAR_W-1:0] ch);
      return {bg, fg, ch};
    endfunction

    function bit next_line();
      col = '0;
      if (row + 1 >= ROWS) begin
        for (int i = 0; i < CELL_COUNT - COLS; i++) cells[i] = cells[i + COLS];
        for (int i = CELL_COUNT - COLS; i < CELL_COUNT; i++) cells[i] = colored(CHAR_SPACE);
        row = 5'(ROWS - 1);
        return 1'b1;
      end
      row = row + 5'd1;
      return 1'b0;
    endfunction

    function bit step_columns(int n);
      int c;
      c = col + n;
      if (c >= COLS) return next_line();
      col = 7'(c);
      return 1'b0;
    endfunction

    function void note_beat(logic cmd, logic [CHAR_W-1:0] ch, logic [INDEX_W-1:0] idx);
      console_beat_t r;
      op_t op;
      r = '0;
      if (cmd == CMD_READ) op = OP_READ;
      else begin
        case (ch)
          CHAR_NEWLINE:   op = OP_NEWLINE;
          CHAR_RETURN:    op = OP_RETURN;
          CHAR_TAB:       op = OP_TAB;
          CHAR_BACKSPACE: op = OP_BACKSPACE;
          default:        op = OP_PUT;
        endcase
      end
      case (op)
        OP_READ: begin
          if (idx < CELL_COUNT) r.read_data = cells[idx];
        end
        OP_NEWLINE: r.scrolled = next_line();
        OP_RETURN:  col = '0;
        OP_TAB:     r.scrolled = step_columns(TAB_STEP);
        OP_BACKSPACE: begin
          if (col > 0) begin
            col = col - 7'd1;
            cells[row * COLS + col] = colored(CHAR_SPACE);
          end else if (row > 0) begin
            row = row - 5'd1;
            cells[row * COLS] = colored(CHAR_SPACE);
          end
        end
        default: begin
          cells[row * COLS + col] = colored(ch);
          r.scrolled = step_columns(1);
        end
      endcase
      r.cursor_index = INDEX_W'(row * COLS + col);
      if (op == OP_READ) reads++;
      else puts++;
      if (r.scrolled) scrolls++;
      awaited.push_back(r);
    endfunction

    function void check_beat(logic [CELL_W-1:0] rd, logic [INDEX_W-1:0] ci, logic sc);
      console_beat_t e;
      if (awaited.size() == 0) begin
        $error("result beat with nothing awaited: read_data %h cursor_index %0d scrolled %0d",
               rd, ci, sc);
        errors++;
        return;
      end
      e = awaited.pop_front();
      checked++;
      if (rd !== e.read_data) begin
        $error("read_data: expected %h, got %h", e.read_data, rd);
        errors++;
      end
      if (ci !== e.cursor_index) begin
        $error("cursor_index: expected %0d, got %0d", e.cursor_index, ci);
        errors++;
      end
      if (sc !== e.scrolled) begin
        $error("scrolled: expected %0d, got %0d", e.scrolled, sc);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic in_command;
  logic [CHAR_W-1:0]  in_char_code;
  logic [INDEX_W-1:0] in_cell_index;
  logic out_valid;
  logic out_stall;
  logic [CELL_W-1:0]  out_read_data;
  logic [INDEX_W-1:0] out_cursor_index;
  logic out_scrolled;

  console_shadow shadow = new();
  bit quiet;
  bit hold_request;
  int unsigned cycle_count;

  text_console_character_writer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_char_code     (in_char_code),
    .in_cell_index    (in_cell_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_cursor_index (out_cursor_index),
    .out_scrolled     (out_scrolled)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid && !in_stall) shadow.note_beat(in_command, in_char_code, in_cell_index);
      if (out_valid && !out_stall) shadow.check_beat(out_read_data, out_cursor_index, out_scrolled);
    end
  end

  // receiver side stalls, with one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 15);
      end
    end
  end

  task automatic send_beat(input logic cmd, input logic [CHAR_W-1:0] ch,
                           input logic [INDEX_W-1:0] idx);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_char_code  <= ch;
    in_cell_index <= idx;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic send_random(input int count);
    int pick;
    logic [CHAR_W-1:0] ch;
    logic [INDEX_W-1:0] idx;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      ch = CHAR_W'($urandom_range(255));
      idx = INDEX_W'($urandom_range(2047));
      if (pick < 25) begin
        if ($urandom_range(9) != 0) idx = INDEX_W'($urandom_range(CELL_COUNT - 1));
        send_beat(CMD_READ, ch, idx);
      end else begin
        pick = $urandom_range(99);
        if (pick < 10) ch = CHAR_NEWLINE;
        else if (pick < 15) ch = CHAR_RETURN;
        else if (pick < 22) ch = CHAR_TAB;
        else if (pick < 32) ch = CHAR_BACKSPACE;
        send_beat(CMD_PUT, ch, idx);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic write_colors(input logic [CFG_DATA_W-1:0] fg, input logic [CFG_DATA_W-1:0] bg);
    while (shadow.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FOREGROUND;
    cfg_wdata <= fg;
    shadow.set_color(REG_FOREGROUND, fg);
    @(posedge clk);
    cfg_index <= REG_BACKGROUND;
    cfg_wdata <= bg;
    shadow.set_color(REG_BACKGROUND, bg);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_FOREGROUND;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_command    <= CMD_PUT;
    in_char_code  <= '0;
    in_cell_index <= '0;
    quiet = 1'b0;
    hold_request = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: corners of the cursor and of the fields
    send_beat(CMD_PUT, CHAR_BACKSPACE, '0);
    send_beat(CMD_READ, 8'hFF, 11'd0);
    send_beat(CMD_READ, 8'h00, 11'd1999);
    send_beat(CMD_READ, 8'h00, 11'd2000);
    send_beat(CMD_READ, 8'h00, 11'd2047);
    send_beat(CMD_PUT, 8'h41, 11'd2047);
    send_beat(CMD_PUT, 8'h00, '0);
    send_beat(CMD_PUT, 8'hFF, '0);
    send_beat(CMD_PUT, 8'h80, '0);
    send_beat(CMD_PUT, 8'h7F, '0);
    send_beat(CMD_PUT, CHAR_BACKSPACE, '0);
    send_beat(CMD_PUT, CHAR_TAB, '0);
    send_beat(CMD_PUT, CHAR_TAB, '0);
    send_beat(CMD_PUT, CHAR_RETURN, '0);
    send_beat(CMD_PUT, 8'h55, '0);
    send_beat(CMD_PUT, CHAR_NEWLINE, '0);
    send_beat(CMD_PUT, CHAR_BACKSPACE, '0);
    send_beat(CMD_PUT, CHAR_NEWLINE, '0);
    send_beat(CMD_PUT, CHAR_NEWLINE, '0);
    send_beat(CMD_READ, '0, 11'd0);
    send_beat(CMD_READ, '0, 11'd1);
    send_beat(CMD_READ, '0, 11'd2);
    send_beat(CMD_READ, '0, 11'd3);
    send_beat(CMD_READ, '0, 11'd4);
    send_random(200);

    write_colors(4'hF, 4'hF);
    quiet = 1'b1;
    send_random(200);
    quiet = 1'b0;

    write_colors(4'h0, 4'h0);
    hold_request = 1'b1;
    send_random(200);

    write_colors(CFG_DATA_W'($urandom_range(15)), CFG_DATA_W'($urandom_range(15)));
    send_random(300);

    write_colors(4'hA, 4'h5);
    send_random(300);

    while (shadow.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d puts and %0d reads over five color settings, %0d scrolls",
             shadow.puts, shadow.reads, shadow.scrolls);
    $display("%0d result beats compared, %0d mismatches", shadow.checked, shadow.errors);
    if (shadow.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
